FILE: hdl/fvt_pkg.sv
package fvt_pkg;

   // Plane register file: six 64-bit registers at byte addresses 8*i.
   localparam int NUM_PLANES     = 6;
   localparam int NUM_CORNERS    = 8;
   localparam int PLANE_WIDTH    = 64;
   localparam int COEF_WIDTH     = 16;
   localparam int D_WIDTH        = 16;
   localparam int CSR_ADDR_WIDTH = 6;
   localparam int CSR_INDEX_LSB  = 3;
   localparam int CSR_INDEX_BITS = CSR_ADDR_WIDTH - CSR_INDEX_LSB;

   // Field positions inside a plane register.
   localparam int A_LSB = 48;
   localparam int B_LSB = 32;
   localparam int C_LSB = 16;
   localparam int D_LSB = 0;

   typedef logic [1:0] fvt_action_type;

   localparam fvt_action_type ACT_SPHERE     = 2'd0;
   localparam fvt_action_type ACT_BOX_ANY    = 2'd1;
   localparam fvt_action_type ACT_BOX_INSIDE = 2'd2;
   localparam fvt_action_type ACT_UNUSED     = 2'd3;

   // Per-plane outcome of one test.
   typedef struct packed {
      logic sphere_above;  // center distance is above minus radius
      logic any_above;     // at least one box corner strictly above the plane
      logic all_above;     // every box corner strictly above the plane
   } fvt_flags_type;

endpackage

FILE: hdl/frustum_visibility_test.sv
// A word accepted at the input passes through the input, product, plane-flag and result
// registers before it shows on rsp_*.
// Throughput: one word per cycle unless every stage is full and stalled; idle stages always fill.
// Reset (synchronous, active high) empties the pipeline and clears all six plane
// registers to zero; there is no clearing pass.
module frustum_visibility_test #(
   parameter int PLANE_COUNT    = 6,
   parameter int COORD_WIDTH    = 16,
   parameter int COEF_FRAC_BITS = 14
) (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  fvt_pkg::fvt_action_type               req_action,
   input  logic signed [COORD_WIDTH-1:0]         req_pos_x,
   input  logic signed [COORD_WIDTH-1:0]         req_pos_y,
   input  logic signed [COORD_WIDTH-1:0]         req_pos_z,
   input  logic signed [COORD_WIDTH-1:0]         req_max_x,
   input  logic signed [COORD_WIDTH-1:0]         req_max_y,
   input  logic signed [COORD_WIDTH-1:0]         req_max_z,
   input  logic [COORD_WIDTH-2:0]                req_radius,

   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_visible,

   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [fvt_pkg::CSR_ADDR_WIDTH-1:0]    csr_paddr,
   input  logic [fvt_pkg::PLANE_WIDTH-1:0]       csr_pwdata,
   output logic [fvt_pkg::PLANE_WIDTH-1:0]       csr_prdata,
   output logic                                  csr_pready
);

   localparam int RW = COORD_WIDTH - 1;

   // Plane registers.
   logic [fvt_pkg::PLANE_WIDTH-1:0]    plane_ff [fvt_pkg::NUM_PLANES];
   logic [fvt_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic                               csr_index_ok;
   logic                               csr_write;

   assign csr_index    = csr_paddr[fvt_pkg::CSR_ADDR_WIDTH-1:fvt_pkg::CSR_INDEX_LSB];
   assign csr_index_ok = csr_index < fvt_pkg::CSR_INDEX_BITS'(fvt_pkg::NUM_PLANES);
   assign csr_write    = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready   = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < fvt_pkg::NUM_PLANES; i++) begin
            plane_ff[i] <= '0;
         end
      end else if (csr_write && csr_index_ok) begin
         plane_ff[csr_index] <= csr_pwdata;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_index_ok) begin
         csr_prdata = plane_ff[csr_index];
      end
   end

   // Pipeline handshake: a stage loads whenever it is empty or the next one moves.
   logic v1_ff, v2_ff, v3_ff, rsp_valid_ff;
   logic ready1, ready2, ready3, ready4;

   assign ready4    = !rsp_valid_ff || !rsp_stall;
   assign ready3    = !v3_ff || ready4;
   assign ready2    = !v2_ff || ready3;
   assign ready1    = !v1_ff || ready2;
   assign req_stall = !ready1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ready1) v1_ff        <= req_valid;
         if (ready2) v2_ff        <= v1_ff;
         if (ready3) v3_ff        <= v2_ff;
         if (ready4) rsp_valid_ff <= v3_ff;
      end
   end

   // Input register.
   fvt_pkg::fvt_action_type      action1_ff, action2_ff, action3_ff;
   logic signed [COORD_WIDTH-1:0] lo_x_ff, lo_y_ff, lo_z_ff, hi_x_ff, hi_y_ff, hi_z_ff;
   logic [RW-1:0]                 radius_ff;

   always_ff @(posedge clock) begin
      if (ready1) begin
         action1_ff <= req_action;
         lo_x_ff    <= req_pos_x;
         lo_y_ff    <= req_pos_y;
         lo_z_ff    <= req_pos_z;
         hi_x_ff    <= req_max_x;
         hi_y_ff    <= req_max_y;
         hi_z_ff    <= req_max_z;
         radius_ff  <= req_radius;
      end
      if (ready2) action2_ff <= action1_ff;
      if (ready3) action3_ff <= action2_ff;
   end

   // One plane unit per tested plane.
   fvt_pkg::fvt_flags_type flags [PLANE_COUNT];

   for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
      fvt_plane #(
         .COORD_WIDTH   (COORD_WIDTH),
         .COEF_FRAC_BITS(COEF_FRAC_BITS)
      ) u_plane (
         .clock     (clock),
         .prod_en   (ready2),
         .flag_en   (ready3),
         .plane_word(plane_ff[p]),
         .lo_x      (lo_x_ff),
         .lo_y      (lo_y_ff),
         .lo_z      (lo_z_ff),
         .hi_x      (hi_x_ff),
         .hi_y      (hi_y_ff),
         .hi_z      (hi_z_ff),
         .radius    (radius_ff),
         .flags     (flags[p])
      );
   end

   // Result register.
   logic all_sphere, all_any, all_inside;
   logic visible_in, rsp_visible_ff;

   always_comb begin
      all_sphere = 1'b1;
      all_any    = 1'b1;
      all_inside = 1'b1;
      for (int p = 0; p < PLANE_COUNT; p++) begin
         all_sphere = all_sphere && flags[p].sphere_above;
         all_any    = all_any && flags[p].any_above;
         all_inside = all_inside && flags[p].all_above;
      end
      case (action3_ff)
         fvt_pkg::ACT_SPHERE:     visible_in = all_sphere;
         fvt_pkg::ACT_BOX_ANY:    visible_in = all_any;
         fvt_pkg::ACT_BOX_INSIDE: visible_in = all_inside;
         default:                 visible_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ready4) begin
         rsp_visible_ff <= visible_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_visible = rsp_visible_ff;

   // The input is only held off when every stage holds a word.
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v1_ff && v2_ff && v3_ff && rsp_valid_ff))
      else $error("input stalled with an empty pipeline stage");

   // An unused action code always yields a culled result.
   a_unused_action_culled: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && ready4 && action3_ff == fvt_pkg::ACT_UNUSED) |=> !rsp_visible_ff)
      else $error("unused action code gave a visible result");

   // A result can only appear if a word was in the flag stage.
   a_result_has_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(v3_ff))
      else $error("result appeared without a word in the flag stage");

   // Reset empties the pipeline.
   a_reset_empties: assert property (@(posedge clock)
      reset |=> (!rsp_valid_ff && !v1_ff && !v2_ff && !v3_ff))
      else $error("pipeline not empty after reset");

endmodule

FILE: hdl/fvt_plane.sv
module fvt_plane #(
   parameter int COORD_WIDTH    = 16,
   parameter int COEF_FRAC_BITS = 14
) (
   input  logic                                clock,
   input  logic                                prod_en,
   input  logic                                flag_en,
   input  logic [fvt_pkg::PLANE_WIDTH-1:0]     plane_word,
   input  logic signed [COORD_WIDTH-1:0]       lo_x,
   input  logic signed [COORD_WIDTH-1:0]       lo_y,
   input  logic signed [COORD_WIDTH-1:0]       lo_z,
   input  logic signed [COORD_WIDTH-1:0]       hi_x,
   input  logic signed [COORD_WIDTH-1:0]       hi_y,
   input  logic signed [COORD_WIDTH-1:0]       hi_z,
   input  logic [COORD_WIDTH-2:0]              radius,
   output fvt_pkg::fvt_flags_type              flags
);

   localparam int PW  = fvt_pkg::COEF_WIDTH + COORD_WIDTH;
   localparam int DW  = fvt_pkg::D_WIDTH + COEF_FRAC_BITS;
   localparam int SW  = ((PW > DW) ? PW : DW) + 3;

   logic signed [fvt_pkg::COEF_WIDTH-1:0] coef_a, coef_b, coef_c;
   logic signed [fvt_pkg::D_WIDTH-1:0]    coef_d;

   logic signed [PW-1:0] prod_lo_in [3];
   logic signed [PW-1:0] prod_hi_in [3];
   logic signed [PW-1:0] prod_lo_ff [3];
   logic signed [PW-1:0] prod_hi_ff [3];
   logic signed [SW-1:0] dterm_in, dterm_ff;
   logic signed [SW-1:0] sph_off_in, sph_off_ff;

   logic signed [SW-1:0]         corner_dist [fvt_pkg::NUM_CORNERS];
   logic signed [SW-1:0]         sph_dist;
   logic [fvt_pkg::NUM_CORNERS-1:0] above;
   fvt_pkg::fvt_flags_type       flags_in, flags_ff;

   assign coef_a = plane_word[fvt_pkg::A_LSB +: fvt_pkg::COEF_WIDTH];
   assign coef_b = plane_word[fvt_pkg::B_LSB +: fvt_pkg::COEF_WIDTH];
   assign coef_c = plane_word[fvt_pkg::C_LSB +: fvt_pkg::COEF_WIDTH];
   assign coef_d = plane_word[fvt_pkg::D_LSB +: fvt_pkg::D_WIDTH];

   // Only six distinct products exist per plane; every corner is a sum of three of them.
   always_comb begin
      prod_lo_in[0] = PW'(coef_a) * PW'(lo_x);
      prod_lo_in[1] = PW'(coef_b) * PW'(lo_y);
      prod_lo_in[2] = PW'(coef_c) * PW'(lo_z);
      prod_hi_in[0] = PW'(coef_a) * PW'(hi_x);
      prod_hi_in[1] = PW'(coef_b) * PW'(hi_y);
      prod_hi_in[2] = PW'(coef_c) * PW'(hi_z);
      dterm_in      = SW'(coef_d) <<< COEF_FRAC_BITS;
      sph_off_in    = dterm_in + ($signed(SW'(radius)) <<< COEF_FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (prod_en) begin
         prod_lo_ff <= prod_lo_in;
         prod_hi_ff <= prod_hi_in;
         dterm_ff   <= dterm_in;
         sph_off_ff <= sph_off_in;
      end
   end

   always_comb begin
      for (int k = 0; k < fvt_pkg::NUM_CORNERS; k++) begin
         corner_dist[k] = (k[0] ? SW'(prod_hi_ff[0]) : SW'(prod_lo_ff[0]))
                        + (k[1] ? SW'(prod_hi_ff[1]) : SW'(prod_lo_ff[1]))
                        + (k[2] ? SW'(prod_hi_ff[2]) : SW'(prod_lo_ff[2]))
                        + dterm_ff;
         above[k] = !corner_dist[k][SW-1] && (corner_dist[k] != '0);
      end
      sph_dist = SW'(prod_lo_ff[0]) + SW'(prod_lo_ff[1]) + SW'(prod_lo_ff[2]) + sph_off_ff;
      flags_in.sphere_above = !sph_dist[SW-1] && (sph_dist != '0);
      flags_in.any_above    = |above;
      flags_in.all_above    = &above;
   end

   always_ff @(posedge clock) begin
      if (flag_en) begin
         flags_ff <= flags_in;
      end
   end

   assign flags = flags_ff;

endmodule
